// ----- rtl/core/mte_pkg.sv -----
// Shared types and constants of the multiturn encoder tracker.
package mte_pkg;

  localparam int CHANNEL_W = 3;
  localparam int CH_CMP_W  = CHANNEL_W + 2;
  localparam int WORD_W    = 16;
  localparam int ANGLE_W   = 14;
  localparam int TURNS_W   = 8;
  localparam int POS_W     = 16;
  localparam int TICKS_W   = 15;
  localparam int TENTHS_W  = 12;

  localparam int NUM_CHANNELS_DEF = 5;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 15'd4096;

  // raw word layout: parity in bit 15, error flag in bit 14, angle below
  localparam int ERR_BIT = 14;

  localparam logic [ANGLE_W-1:0] WRAP_HIGH = 14'h3F00;
  localparam logic [ANGLE_W-1:0] WRAP_LOW  = 14'h0FF0;

  // angle * 3600 / 16384 == angle * 225 / 1024
  localparam int TENTHS_PROD_W = ANGLE_W + 8;
  localparam int TENTHS_SHIFT  = 10;
  localparam logic [TENTHS_PROD_W-1:0] TENTHS_MUL = 22'd225;

  // position product: {1'b0, ticks} * {turns, angle}, signed
  localparam int PROD_W = (TICKS_W + 1) + (TURNS_W + ANGLE_W);

  typedef struct packed {
    logic                fault;
    logic [ANGLE_W-1:0]  angle;
    logic [TURNS_W-1:0]  turns;
  } mte_state_t;

  typedef struct packed {
    logic                valid;
    logic                in_range;
    logic                bad;
    logic                fault;
    logic [ANGLE_W-1:0]  angle;
    logic [TURNS_W-1:0]  turns;
    logic [POS_W-1:0]    pos;
  } mte_stage_t;

endpackage

// ----- rtl/core/mte_ram.sv -----
// Per-channel state memory: one read and one write port, registered read with write bypass.
module mte_ram import mte_pkg::*; #(
  parameter int DEPTH  = NUM_CHANNELS_DEF,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // entries never written read as zero; a write on the same edge wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data_r <= wr_data;
      end else if (valid_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/mte_track.sv -----
// Sample check and turn tracking: input register, read-modify-write of channel state.
module mte_track import mte_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int ADDR_W       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 in_accept,
  input  logic [CHANNEL_W-1:0] in_channel,
  input  logic [WORD_W-1:0]    in_spi_word,
  output logic [ADDR_W-1:0]    rd_addr,
  input  mte_state_t           st_rd,
  input  logic [POS_W-1:0]     pos_rd,
  output logic                 st_wr_en,
  output logic [ADDR_W-1:0]    st_wr_addr,
  output mte_state_t           st_wr_data,
  output mte_stage_t           s2,
  output logic [ADDR_W-1:0]    s2_addr
);

  logic                in_range;
  logic                s1_valid_r;
  logic                s1_in_range_r;
  logic                s1_bad_r;
  logic [ANGLE_W-1:0]  s1_angle_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic                good;
  logic                wrap_dn;
  logic                wrap_up;
  mte_state_t          st_nxt;
  mte_stage_t          s2_nxt;
  mte_stage_t          s2_r;
  logic [ADDR_W-1:0]   s2_addr_r;

  assign in_range = CH_CMP_W'(in_channel) < CH_CMP_W'(NUM_CHANNELS);
  assign rd_addr  = in_range ? ADDR_W'(in_channel) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_in_range_r <= in_range;
      s1_bad_r      <= in_spi_word[ERR_BIT] | (^in_spi_word);
      s1_angle_r    <= in_spi_word[ANGLE_W-1:0];
      s1_addr_r     <= rd_addr;
    end
  end

  assign good    = s1_in_range_r & ~s1_bad_r;
  assign wrap_dn = (s1_angle_r > WRAP_HIGH) && (st_rd.angle < WRAP_LOW);
  assign wrap_up = (st_rd.angle > WRAP_HIGH) && (s1_angle_r < WRAP_LOW);

  always_comb begin
    st_nxt       = st_rd;
    st_nxt.fault = st_rd.fault | s1_bad_r;
    if (good) begin
      st_nxt.angle = s1_angle_r;
      if (wrap_dn) begin
        st_nxt.turns = st_rd.turns - TURNS_W'(1);
      end else if (wrap_up) begin
        st_nxt.turns = st_rd.turns + TURNS_W'(1);
      end
    end
  end

  assign st_wr_en   = advance & s1_valid_r & s1_in_range_r;
  assign st_wr_addr = s1_addr_r;
  assign st_wr_data = st_nxt;

  always_comb begin
    s2_nxt          = '0;
    s2_nxt.valid    = s1_valid_r;
    s2_nxt.in_range = s1_in_range_r;
    s2_nxt.bad      = s1_bad_r;
    s2_nxt.fault    = st_nxt.fault;
    s2_nxt.angle    = st_nxt.angle;
    s2_nxt.turns    = st_nxt.turns;
    s2_nxt.pos      = pos_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (advance) begin
      s2_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_addr_r <= s1_addr_r;
    end
  end

  assign s2      = s2_r;
  assign s2_addr = s2_addr_r;

endmodule

// ----- rtl/core/mte_scale.sv -----
// Position scaling, tenths of a degree and the output register.
module mte_scale import mte_pkg::*; #(
  parameter int ADDR_W = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [TICKS_W-1:0]         ticks,
  input  mte_stage_t                 s2,
  input  logic [ADDR_W-1:0]          s2_addr,
  output logic                       pos_wr_en,
  output logic [ADDR_W-1:0]          pos_wr_addr,
  output logic [POS_W-1:0]           pos_wr_data,
  output logic                       out_valid,
  output logic                       out_sample_bad,
  output logic                       out_sticky_fault,
  output logic [ANGLE_W-1:0]         out_angle,
  output logic signed [TURNS_W-1:0]  out_turns,
  output logic signed [POS_W-1:0]    out_position_ticks,
  output logic [TENTHS_W-1:0]        out_tenths_degree
);

  logic signed [PROD_W-1:0]   prod;
  logic [POS_W-1:0]           new_pos;
  logic [TENTHS_PROD_W-1:0]   tenths_full;
  logic                       good;
  logic                       fwd;
  logic [POS_W-1:0]           pos_sel;

  logic                       out_valid_r;
  logic                       out_bad_r;
  logic                       out_fault_r;
  logic [ANGLE_W-1:0]         out_angle_r;
  logic [TURNS_W-1:0]         out_turns_r;
  logic [POS_W-1:0]           out_pos_r;
  logic [TENTHS_W-1:0]        out_tenths_r;
  logic [ADDR_W-1:0]          s3_addr_r;
  logic                       s3_good_r;

  logic                       bad_nxt;
  logic                       fault_nxt;
  logic [ANGLE_W-1:0]         angle_nxt;
  logic [TURNS_W-1:0]         turns_nxt;
  logic [POS_W-1:0]           pos_nxt;
  logic [TENTHS_W-1:0]        tenths_nxt;

  // ((angle*t) >> 14) + t*turns == (t * {turns, angle}) >> 14
  assign prod    = $signed({1'b0, ticks}) * $signed({s2.turns, s2.angle});
  assign new_pos = prod[ANGLE_W +: POS_W];

  assign tenths_full = TENTHS_PROD_W'(s2.angle) * TENTHS_MUL;

  assign good = s2.in_range & ~s2.bad;

  // the item one ahead may have just stored this channel's position
  assign fwd = out_valid_r & s3_good_r & (s3_addr_r == s2_addr);

  always_comb begin
    if (good) begin
      pos_sel = new_pos;
    end else if (fwd) begin
      pos_sel = out_pos_r;
    end else begin
      pos_sel = s2.pos;
    end
  end

  always_comb begin
    bad_nxt    = 1'b0;
    fault_nxt  = 1'b0;
    angle_nxt  = '0;
    turns_nxt  = '0;
    pos_nxt    = '0;
    tenths_nxt = '0;
    if (s2.in_range) begin
      bad_nxt    = s2.bad;
      fault_nxt  = s2.fault;
      angle_nxt  = s2.angle;
      turns_nxt  = s2.turns;
      pos_nxt    = pos_sel;
      tenths_nxt = tenths_full[TENTHS_SHIFT +: TENTHS_W];
    end
  end

  assign pos_wr_en   = advance & s2.valid & good;
  assign pos_wr_addr = s2_addr;
  assign pos_wr_data = new_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bad_r    <= bad_nxt;
      out_fault_r  <= fault_nxt;
      out_angle_r  <= angle_nxt;
      out_turns_r  <= turns_nxt;
      out_pos_r    <= pos_nxt;
      out_tenths_r <= tenths_nxt;
      s3_addr_r    <= s2_addr;
      s3_good_r    <= good;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_bad     = out_bad_r;
  assign out_sticky_fault   = out_fault_r;
  assign out_angle          = out_angle_r;
  assign out_turns          = $signed(out_turns_r);
  assign out_position_ticks = $signed(out_pos_r);
  assign out_tenths_degree  = out_tenths_r;

endmodule

// ----- rtl/core/multiturn_encoder_tracker.sv -----
// Top level of the multiturn encoder tracker.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------------
//   in_      | input     | in_valid / in_ready    | channel, spi_word
//   out_     | output    | out_valid / out_ready  | sample_bad .. tenths_degree
//   cfg_     | input     | cfg_valid / cfg_ready  | ticks_per_turn
//
// One item per cycle unless a held output stalls the pipe; after its transfer in, each result
// passes the input register, state memory read-modify-write, scale and output register.
// The state memory has a registered read; same-channel overlap is covered
// by write bypass in the memory and a position forward from the output register.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// A held output stalls the whole pipe; in_ready drops only then. cfg_ready is always high.
module multiturn_encoder_tracker import mte_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CHANNEL_W-1:0]       in_channel,
  input  logic [WORD_W-1:0]          in_spi_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_sample_bad,
  output logic                       out_sticky_fault,
  output logic [ANGLE_W-1:0]         out_angle,
  output logic signed [TURNS_W-1:0]  out_turns,
  output logic signed [POS_W-1:0]    out_position_ticks,
  output logic [TENTHS_W-1:0]        out_tenths_degree,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [TICKS_W-1:0]         cfg_ticks_per_turn
);

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ST_W   = $bits(mte_state_t);

  logic                advance;
  logic                in_accept;
  logic [TICKS_W-1:0]  ticks_r;

  logic [ADDR_W-1:0]   rd_addr;
  mte_state_t          st_rd;
  logic [POS_W-1:0]    pos_rd;
  logic                st_wr_en;
  logic [ADDR_W-1:0]   st_wr_addr;
  mte_state_t          st_wr_data;
  logic                pos_wr_en;
  logic [ADDR_W-1:0]   pos_wr_addr;
  logic [POS_W-1:0]    pos_wr_data;
  mte_stage_t          s2;
  logic [ADDR_W-1:0]   s2_addr;

  assign advance   = ~out_valid | out_ready;
  assign in_ready  = advance;
  assign in_accept = in_valid & advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_valid) begin
      ticks_r <= cfg_ticks_per_turn;
    end
  end

  mte_ram #(
    .DEPTH  (NUM_CHANNELS),
    .ADDR_W (ADDR_W),
    .DATA_W (ST_W)
  ) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (st_rd),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  mte_ram #(
    .DEPTH  (NUM_CHANNELS),
    .ADDR_W (ADDR_W),
    .DATA_W (POS_W)
  ) u_pos_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (pos_rd),
    .wr_en   (pos_wr_en),
    .wr_addr (pos_wr_addr),
    .wr_data (pos_wr_data)
  );

  mte_track #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ADDR_W       (ADDR_W)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .in_accept   (in_accept),
    .in_channel  (in_channel),
    .in_spi_word (in_spi_word),
    .rd_addr     (rd_addr),
    .st_rd       (st_rd),
    .pos_rd      (pos_rd),
    .st_wr_en    (st_wr_en),
    .st_wr_addr  (st_wr_addr),
    .st_wr_data  (st_wr_data),
    .s2          (s2),
    .s2_addr     (s2_addr)
  );

  mte_scale #(
    .ADDR_W (ADDR_W)
  ) u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .ticks              (ticks_r),
    .s2                 (s2),
    .s2_addr            (s2_addr),
    .pos_wr_en          (pos_wr_en),
    .pos_wr_addr        (pos_wr_addr),
    .pos_wr_data        (pos_wr_data),
    .out_valid          (out_valid),
    .out_sample_bad     (out_sample_bad),
    .out_sticky_fault   (out_sticky_fault),
    .out_angle          (out_angle),
    .out_turns          (out_turns),
    .out_position_ticks (out_position_ticks),
    .out_tenths_degree  (out_tenths_degree)
  );

endmodule

// ----- rtl/core/mte_checker.sv -----
// Port-level checks for the multiturn encoder tracker, bound to the top level.
module mte_checker import mte_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_sample_bad,
  input logic                       out_sticky_fault,
  input logic [ANGLE_W-1:0]         out_angle,
  input logic signed [TURNS_W-1:0]  out_turns,
  input logic signed [POS_W-1:0]    out_position_ticks,
  input logic [TENTHS_W-1:0]        out_tenths_degree
);

  localparam logic [TENTHS_W-1:0] TENTHS_MAX = 12'd3599;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position_ticks)
      && $stable(out_angle) && $stable(out_turns) && $stable(out_sticky_fault))
    else $error("result changed while stalled");

  // a rejected word always leaves the channel flagged
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_bad |-> out_sticky_fault)
    else $error("bad sample without sticky fault");

  a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tenths_degree <= TENTHS_MAX)
    else $error("tenths of a degree out of range");

  // input side never blocks while the output register is free
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multiturn_encoder_tracker mte_checker u_mte_checker (.*);

// ----- sim/multiturn_encoder_tracker_test.sv -----
// Self-checking testbench of the multiturn encoder tracker: table and random samples.
`timescale 1ns / 100ps

module multiturn_encoder_tracker_test;
  import mte_pkg::*;

  localparam int NUM_CH          = NUM_CHANNELS_DEF;
  localparam int TENTHS_PER_TURN = 3600;
  localparam int FULL_TURN       = 16384;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 250;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int STALL_PCT       = 79;
  localparam int BOTH_PCT        = 25;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                       bad;
    logic                       fault;
    logic [ANGLE_W-1:0]         angle;
    logic signed [TURNS_W-1:0]  turns;
    logic signed [POS_W-1:0]    pos;
    logic [TENTHS_W-1:0]        tenths;
  } tracker_result_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]  ch;
    logic [WORD_W-1:0]     word;
    logic                  typed;
    tracker_result_t       res;
  } sample_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;

  localparam tracker_result_t ZERO_RES  = '0;
  localparam tracker_result_t BAD_FRESH = '{bad: 1'b1, fault: 1'b1, default: '0};
  localparam tracker_result_t FIRST_DOWN_WRAP = '{bad: 1'b0, fault: 1'b0,
      angle: 14'h3FFF, turns: -8'sd1, pos: -16'sd1, tenths: 12'd3599};

  localparam int DIR_ROWS = 25;
  localparam sample_row_t SAMPLE_TABLE [DIR_ROWS] = '{
    '{3'd0, 16'h0000, TYPED, ZERO_RES},         // zero angle on a fresh channel
    '{3'd7, 16'hFFFF, TYPED, ZERO_RES},         // channels out of range
    '{3'd5, 16'h3FFF, TYPED, ZERO_RES},
    '{3'd6, 16'h0000, TYPED, ZERO_RES},
    '{3'd1, 16'h4000, TYPED, BAD_FRESH},        // error bit and odd parity
    '{3'd2, 16'hC000, TYPED, BAD_FRESH},        // error bit alone
    '{3'd3, 16'h0001, TYPED, BAD_FRESH},        // odd parity alone
    '{3'd4, 16'hFFFF, TYPED, BAD_FRESH},
    '{3'd0, 16'h3FFF, TYPED, FIRST_DOWN_WRAP},  // wrap down from zero
    '{3'd0, 16'h0000, PRED,  ZERO_RES},         // wrap up again
    '{3'd0, 16'h3FFF, PRED,  ZERO_RES},
    '{3'd0, 16'hA000, PRED,  ZERO_RES},
    '{3'd0, 16'h0000, PRED,  ZERO_RES},
    '{3'd0, 16'hBFFF, PRED,  ZERO_RES},         // rejected, state held
    '{3'd1, 16'h8001, PRED,  ZERO_RES},         // good word, fault stays set
    '{3'd3, 16'h3F00, PRED,  ZERO_RES},         // thresholds are exclusive
    '{3'd3, 16'h0000, PRED,  ZERO_RES},
    '{3'd3, 16'hBF01, PRED,  ZERO_RES},
    '{3'd3, 16'h0FF0, PRED,  ZERO_RES},
    '{3'd3, 16'h8FEF, PRED,  ZERO_RES},
    '{3'd3, 16'hBF01, PRED,  ZERO_RES},
    '{3'd3, 16'h8FEF, PRED,  ZERO_RES},
    '{3'd2, 16'h9555, PRED,  ZERO_RES},
    '{3'd2, 16'hAAAA, PRED,  ZERO_RES},
    '{3'd4, 16'h0000, PRED,  ZERO_RES}
  };

  localparam logic [TICKS_W-1:0] PHASE_TICKS [PHASES] = '{
    15'd1, 15'd16384, 15'd0, 15'd32767, 15'd360, 15'd0, 15'd4096, 15'd0
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CHANNEL_W-1:0]       in_channel = '0;
  logic [WORD_W-1:0]          in_spi_word = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_sample_bad;
  logic                       out_sticky_fault;
  logic [ANGLE_W-1:0]         out_angle;
  logic signed [TURNS_W-1:0]  out_turns;
  logic signed [POS_W-1:0]    out_position_ticks;
  logic [TENTHS_W-1:0]        out_tenths_degree;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [TICKS_W-1:0]         cfg_ticks_per_turn = '0;

  multiturn_encoder_tracker u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_channel         (in_channel),
    .in_spi_word        (in_spi_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_bad     (out_sample_bad),
    .out_sticky_fault   (out_sticky_fault),
    .out_angle          (out_angle),
    .out_turns          (out_turns),
    .out_position_ticks (out_position_ticks),
    .out_tenths_degree  (out_tenths_degree),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_ticks_per_turn (cfg_ticks_per_turn)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracked copy of the per-channel state
  logic [TICKS_W-1:0]         ticks_now;
  logic [ANGLE_W-1:0]         chan_angle [NUM_CH];
  logic signed [TURNS_W-1:0]  chan_turns [NUM_CH];
  logic                       chan_fault [NUM_CH];
  logic [POS_W-1:0]           chan_pos   [NUM_CH];

  tracker_result_t pending_results [$];
  idle_mode_t      idle_mode = IDLE_NONE;
  int              error_count = 0;
  int              results_seen = 0;
  int              cycle_count = 0;
  int              spin_step [NUM_CH];

  function automatic tracker_result_t track_sample(logic [CHANNEL_W-1:0] ch,
                                                   logic [WORD_W-1:0] w);
    tracker_result_t r;
    logic [ANGLE_W-1:0] a;
    logic [ANGLE_W-1:0] prev;
    int frac;
    int whole;
    r = '0;
    if (int'(ch) >= NUM_CH) return r;
    if (w[ERR_BIT] || ^w) begin
      chan_fault[ch] = 1'b1;
      r.bad = 1'b1;
    end else begin
      a = w[ANGLE_W-1:0];
      prev = chan_angle[ch];
      if (a > WRAP_HIGH && prev < WRAP_LOW) chan_turns[ch] = chan_turns[ch] - 8'sd1;
      else if (prev > WRAP_HIGH && a < WRAP_LOW) chan_turns[ch] = chan_turns[ch] + 8'sd1;
      chan_angle[ch] = a;
      frac = (int'(a) * int'(ticks_now)) >> ANGLE_W;
      whole = int'(ticks_now) * int'(chan_turns[ch]);
      chan_pos[ch] = 16'(frac + whole);
    end
    r.fault  = chan_fault[ch];
    r.angle  = chan_angle[ch];
    r.turns  = chan_turns[ch];
    r.pos    = chan_pos[ch];
    r.tenths = 12'((int'(chan_angle[ch]) * TENTHS_PER_TURN) / FULL_TURN);
    return r;
  endfunction

  // even parity over the whole word, error bit clear
  function automatic logic [WORD_W-1:0] good_word(logic [ANGLE_W-1:0] a);
    return {^a, 1'b0, a};
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("result %0d: %s got %h expected %h", results_seen, field, got, want);
  endtask

  // enter and leave at a falling edge; valid stays up when the next item follows at once
  task automatic send_sample(logic [CHANNEL_W-1:0] ch, logic [WORD_W-1:0] w,
                             logic typed, tracker_result_t typed_res);
    tracker_result_t pred;
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? STALL_PCT : (idle_mode == IDLE_BOTH) ? BOTH_PCT : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_channel  <= ch;
    in_spi_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = track_sample(ch, w);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_ticks(logic [TICKS_W-1:0] v);
    wait_drained();
    cfg_valid          <= 1'b1;
    cfg_ticks_per_turn <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ticks_now = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    int pct;
    pct = (idle_mode == IDLE_RECEIVER) ? STALL_PCT : (idle_mode == IDLE_BOTH) ? BOTH_PCT : 0;
    out_ready <= ($urandom_range(0, 99) >= pct);
  end

  always @(posedge clk) begin
    tracker_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("no result pending, angle", 32'(out_angle), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_sample_bad !== want.bad)
          report_mismatch("sample_bad", 32'(out_sample_bad), 32'(want.bad));
        if (out_sticky_fault !== want.fault)
          report_mismatch("sticky_fault", 32'(out_sticky_fault), 32'(want.fault));
        if (out_angle !== want.angle)
          report_mismatch("angle", 32'(out_angle), 32'(want.angle));
        if (out_turns !== want.turns)
          report_mismatch("turns", 32'(out_turns), 32'(want.turns));
        if (out_position_ticks !== want.pos)
          report_mismatch("position_ticks", 32'(out_position_ticks), 32'(want.pos));
        if (out_tenths_degree !== want.tenths)
          report_mismatch("tenths_degree", 32'(out_tenths_degree), 32'(want.tenths));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [CHANNEL_W-1:0] ch;
    logic [WORD_W-1:0]    w;
    logic [TICKS_W-1:0]   ticks;
    logic                 spin_down;
    int                   roll;
    int                   counted;
    ticks_now = TICKS_RESET;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_angle[i] = '0;
      chan_turns[i] = '0;
      chan_fault[i] = 1'b0;
      chan_pos[i]   = '0;
      spin_step[i]  = 0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_sample(SAMPLE_TABLE[i].ch, SAMPLE_TABLE[i].word, SAMPLE_TABLE[i].typed,
                  SAMPLE_TABLE[i].res);

    for (int phase = 0; phase < PHASES; phase++) begin
      ticks = PHASE_TICKS[phase];
      if (phase == 5) ticks = 15'($urandom_range(1, 16384));
      if (phase == 7) ticks = 15'($urandom_range(0, 32767));
      write_ticks(ticks);
      idle_mode = idle_mode_t'(phase % 4);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        ch = 3'($urandom_range(0, NUM_CH - 1));
        if (roll < 60) begin
          // spin a channel through low, high and mid zones to pile up turns
          if ($urandom_range(0, 9) < 7) ch = $urandom_range(0, 1) ? 3'd0 : 3'd2;
          spin_down = (ch < 2) || (ch == 4 && $urandom_range(0, 1) == 1);
          case (spin_step[ch])
            0: w = good_word(spin_down ? 14'($urandom_range(0, 'h0FEF))
                                       : 14'($urandom_range('h3F01, 'h3FFF)));
            1: w = good_word(spin_down ? 14'($urandom_range('h3F01, 'h3FFF))
                                       : 14'($urandom_range(0, 'h0FEF)));
            default: w = good_word(14'($urandom_range('h0FF0, 'h3F00)));
          endcase
          spin_step[ch] = (spin_step[ch] + 1) % 3;
        end else if (roll < 75) begin
          w = good_word(14'($urandom_range(0, 16383)));
        end else if (roll < 85) begin
          w = 16'($urandom);
          if (!(w[ERR_BIT] || ^w)) w[WORD_W-1] = ~w[WORD_W-1];
        end else if (roll < 92) begin
          w = 16'($urandom);
        end else begin
          ch = 3'($urandom_range(NUM_CH, 7));
          w = 16'($urandom);
        end
        send_sample(ch, w, PRED, ZERO_RES);
        if (int'(ch) < NUM_CH) counted++;
      end
    end

    wait_drained();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
